// File: src/pssi_pkg.sv
// Package for the sorted-insert priority stack.
// Holds the request and status codes and the control bundle that the top level
// hands to every slot cell. It depends on nothing.
`default_nettype none

package pssi_pkg;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_PRI   = 2'd3;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: src/pssi_cell.sv
// One slot of the sorted priority stack.
// Holds a value and a priority, and on each update keeps its entry, takes the new
// entry, or takes its left or right neighbor's entry. Uses pssi_pkg.
`default_nettype none

module pssi_cell
    import pssi_pkg::*;
#(
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 8
) (
    input  wire                      i_clk,
    input  t_cell_ctl                i_ctl,
    input  wire                      i_occupied,
    input  wire [VALUE_WIDTH-1:0]    i_new_value,
    input  wire [PRIORITY_WIDTH-1:0] i_new_prio,
    input  wire                      i_left_keep,
    input  wire [VALUE_WIDTH-1:0]    i_left_value,
    input  wire [PRIORITY_WIDTH-1:0] i_left_prio,
    input  wire [VALUE_WIDTH-1:0]    i_right_value,
    input  wire [PRIORITY_WIDTH-1:0] i_right_prio,
    output logic                     o_keep,
    output logic [VALUE_WIDTH-1:0]   o_value,
    output logic [PRIORITY_WIDTH-1:0] o_prio
);

    logic [VALUE_WIDTH-1:0]    r_value;
    logic [PRIORITY_WIDTH-1:0] r_prio;
    logic [VALUE_WIDTH-1:0]    n_value;
    logic [PRIORITY_WIDTH-1:0] n_prio;

    // An entry stays in place when it strictly outranks the new one.
    assign o_keep = i_occupied && (r_prio > i_new_prio);

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_ctl.push && !o_keep) begin
            if (i_left_keep) begin
                n_value = i_new_value;
                n_prio  = i_new_prio;
            end else begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end
        end else if (i_ctl.pop) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;

endmodule

`default_nettype wire

// File: src/priority_stack_sorted_insert.sv
// Top level of the sorted-insert priority stack.
// Instantiates a row of pssi_cell slots, the request checks, the result register
// and the configuration port. Uses pssi_pkg.
//
// The stack keeps up to CAPACITY entries in a row of cells sorted by descending
// priority, with cell 0 as the top. A push enters above all stored entries of
// equal priority and a pop removes the top. Every cell compares its priority with
// the incoming one in parallel and shifts with its neighbor, so one request is
// taken per cycle while the output is not stalled; its result beat appears on the
// cycle after acceptance. A new request is taken while the result of the previous
// one is being taken. Rejected requests (push above the priority limit, push when
// full, pop when empty) leave the stack unchanged. No clearing pass follows reset.
`default_nettype none

module priority_stack_sorted_insert
    import pssi_pkg::*;
#(
    parameter int CAPACITY       = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 8
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire                       i_req_type,
    input  wire [VALUE_WIDTH-1:0]     i_elem_value,
    input  wire [PRIORITY_WIDTH-1:0]  i_elem_priority,
    output logic                      o_valid,
    input  wire                       i_stall,
    output logic [1:0]                o_status,
    output logic [VALUE_WIDTH-1:0]    o_top_value,
    output logic [PRIORITY_WIDTH-1:0] o_top_priority,
    output logic                      o_is_empty,
    output logic [4:0]                o_entry_count,
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire [PADDR_W-1:0]         paddr,
    input  wire [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [PRIORITY_WIDTH-1:0] r_max_prio;
    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic [1:0]                n_status;
    logic                      accept;
    logic                      cfg_write;
    t_cell_ctl                 ctl;
    logic [31:0]               count_ext;

    logic [VALUE_WIDTH-1:0]    cell_value [CAPACITY];
    logic [PRIORITY_WIDTH-1:0] cell_prio  [CAPACITY];
    logic                      cell_keep  [CAPACITY];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == 1'b0);
    assign prdata    = (paddr[PADDR_W-1] == 1'b0) ? PDATA_W'(r_max_prio) : '0;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        ctl      = '0;
        if (i_req_type == REQ_PUSH) begin
            if (i_elem_priority > r_max_prio) begin
                n_status = ST_PRI;
            end else if (r_count == CW'(CAPACITY)) begin
                n_status = ST_FULL;
            end else begin
                ctl.push = accept;
                n_count  = r_count + 1'b1;
            end
        end else begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                ctl.pop = accept;
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_max_prio  <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_max_prio <= pwdata[PRIORITY_WIDTH-1:0];
            end
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic                      left_keep;
        logic [VALUE_WIDTH-1:0]    left_value;
        logic [PRIORITY_WIDTH-1:0] left_prio;
        logic [VALUE_WIDTH-1:0]    right_value;
        logic [PRIORITY_WIDTH-1:0] right_prio;

        if (gi == 0) begin : g_first
            assign left_keep  = 1'b1;
            assign left_value = i_elem_value;
            assign left_prio  = i_elem_priority;
        end else begin : g_inner
            assign left_keep  = cell_keep[gi-1];
            assign left_value = cell_value[gi-1];
            assign left_prio  = cell_prio[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[gi];
            assign right_prio  = cell_prio[gi];
        end else begin : g_mid
            assign right_value = cell_value[gi+1];
            assign right_prio  = cell_prio[gi+1];
        end

        pssi_cell #(
            .VALUE_WIDTH   (VALUE_WIDTH),
            .PRIORITY_WIDTH(PRIORITY_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occupied   (CW'(gi) < r_count),
            .i_new_value  (i_elem_value),
            .i_new_prio   (i_elem_priority),
            .i_left_keep  (left_keep),
            .i_left_value (left_value),
            .i_left_prio  (left_prio),
            .i_right_value(right_value),
            .i_right_prio (right_prio),
            .o_keep       (cell_keep[gi]),
            .o_value      (cell_value[gi]),
            .o_prio       (cell_prio[gi])
        );
    end

    assign count_ext      = 32'(r_count);
    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_is_empty     = (r_count == '0);
    assign o_top_value    = o_is_empty ? '0 : cell_value[0];
    assign o_top_priority = o_is_empty ? '0 : cell_prio[0];
    assign o_entry_count  = count_ext[4:0];

endmodule

`default_nettype wire
